FILE: rtl/core/dgtg_pkg.sv
`default_nettype none
package dgtg_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_GATHER  = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_WEIGHT_SHIFT    = 2'd0;
  localparam logic [1:0] REG_TILE_FIRST_COL  = 2'd1;
  localparam logic [1:0] REG_TILE_VALID_COLS = 2'd2;
  localparam logic [1:0] REG_COMPONENT       = 2'd3;

  localparam int SPAN_MAX_HW = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] field_slot;
    logic [31:0] field_value;
    logic [11:0] first_col;
    logic [7:0]  first_row;
    logic [3:0]  col_span;
    logic [3:0]  row_span;
    logic [63:0] px_low;
    logic [63:0] px_high;
    logic [63:0] py_low;
    logic [63:0] py_high;
    logic [11:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [11:0] read_index;
    logic [63:0] grad_x;
    logic [63:0] grad_y;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COL,
    ST_ROW,
    ST_MUL,
    ST_ADD,
    ST_COLEND,
    ST_GRD_RD,
    ST_GRD_WR,
    ST_RD_X,
    ST_RD_Y,
    ST_RD_WAIT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clear_step;
    logic col_start;
    logic row_fetch;
    logic mul_step;
    logic add_step;
    logic col_next;
    logic grad_read;
    logic grad_write;
    logic read_x;
    logic read_y;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic col_done;
    logic col_ok;
    logic row_last;
    logic cell_ok;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/core/dgtg_if.sv
`default_nettype none
interface dgtg_item_if;
  logic                  valid;
  logic                  ready;
  dgtg_pkg::item_t       payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dgtg_result_if;
  logic                  valid;
  logic                  ready;
  dgtg_pkg::result_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dgtg_cfg_if;
  logic                  valid;
  logic                  ready;
  dgtg_pkg::cfg_t        payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/dgtg_ctrl.sv
`default_nettype none
module dgtg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_kind,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dgtg_pkg::cmd_t         cmd,
  input  wire dgtg_pkg::status_t status
);

  dgtg_pkg::state_t state, state_next;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgtg_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dgtg_pkg::ST_CLEAR: begin
        if (status.clear_done) state_next = dgtg_pkg::ST_IDLE;
      end
      dgtg_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            dgtg_pkg::KIND_GATHER: state_next = dgtg_pkg::ST_COL;
            dgtg_pkg::KIND_READ:   state_next = dgtg_pkg::ST_RD_X;
            default:               state_next = dgtg_pkg::ST_IDLE;
          endcase
        end
      end
      dgtg_pkg::ST_COL: begin
        if (status.col_done) state_next = dgtg_pkg::ST_GRD_RD;
        else if (status.col_ok) state_next = dgtg_pkg::ST_ROW;
        else state_next = dgtg_pkg::ST_COLEND;
      end
      dgtg_pkg::ST_ROW: begin
        state_next = dgtg_pkg::ST_MUL;
      end
      dgtg_pkg::ST_MUL: begin
        state_next = dgtg_pkg::ST_ADD;
      end
      dgtg_pkg::ST_ADD: begin
        if (status.row_last) state_next = dgtg_pkg::ST_COLEND;
        else state_next = dgtg_pkg::ST_ROW;
      end
      dgtg_pkg::ST_COLEND: begin
        state_next = dgtg_pkg::ST_COL;
      end
      dgtg_pkg::ST_GRD_RD: begin
        state_next = status.cell_ok ? dgtg_pkg::ST_GRD_WR : dgtg_pkg::ST_IDLE;
      end
      dgtg_pkg::ST_GRD_WR: begin
        state_next = dgtg_pkg::ST_IDLE;
      end
      dgtg_pkg::ST_RD_X: begin
        state_next = dgtg_pkg::ST_RD_Y;
      end
      dgtg_pkg::ST_RD_Y: begin
        state_next = dgtg_pkg::ST_RD_WAIT;
      end
      dgtg_pkg::ST_RD_WAIT: begin
        state_next = dgtg_pkg::ST_OUT;
      end
      dgtg_pkg::ST_OUT: begin
        if (out_ready) state_next = dgtg_pkg::ST_IDLE;
      end
      default: state_next = dgtg_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      dgtg_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
      dgtg_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_fire;
      end
      dgtg_pkg::ST_COL:    cmd.col_start  = 1'b1;
      dgtg_pkg::ST_ROW:    cmd.row_fetch  = 1'b1;
      dgtg_pkg::ST_MUL:    cmd.mul_step   = 1'b1;
      dgtg_pkg::ST_ADD:    cmd.add_step   = 1'b1;
      dgtg_pkg::ST_COLEND: cmd.col_next   = 1'b1;
      dgtg_pkg::ST_GRD_RD: cmd.grad_read  = 1'b1;
      dgtg_pkg::ST_GRD_WR: cmd.grad_write = 1'b1;
      dgtg_pkg::ST_RD_X:   cmd.read_x     = 1'b1;
      dgtg_pkg::ST_RD_Y: begin
        cmd.read_y   = 1'b1;
      end
      dgtg_pkg::ST_OUT:    out_valid      = 1'b1;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != dgtg_pkg::ST_IDLE) |-> !in_ready)
    else $error("input accepted while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");
  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (state == dgtg_pkg::ST_RD_X) |=> (state == dgtg_pkg::ST_RD_Y) ##2 out_valid)
    else $error("read sequence broken");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/dgtg_datapath.sv
`default_nettype none
module dgtg_datapath #(
  parameter int TILE_COLS = 32,
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 4096,
  parameter int CELLS     = 4096,
  parameter int MAX_SPAN  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dgtg_pkg::item_t   item,
  input  wire logic              cfg_fire,
  input  wire dgtg_pkg::cfg_t    cfg,
  input  wire dgtg_pkg::cmd_t    cmd,
  output dgtg_pkg::status_t      status,
  output dgtg_pkg::result_t      result
);

  localparam int TILE_WORDS = TILE_COLS * GRID_ROWS;
  localparam int TW_W  = $clog2(TILE_WORDS);
  localparam int TA_W  = (TW_W < 1) ? 1 : TW_W;
  localparam int GE    = CELLS * 2;
  localparam int GA_W  = $clog2(GE);

  // configuration registers
  logic [4:0]  weight_shift;
  logic [11:0] tile_first_col;
  logic [5:0]  tile_valid_cols;
  logic        component;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_shift    <= '0;
      tile_first_col  <= '0;
      tile_valid_cols <= 6'd32;
      component       <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg.index)
        dgtg_pkg::REG_WEIGHT_SHIFT:    weight_shift    <= cfg.data[4:0];
        dgtg_pkg::REG_TILE_FIRST_COL:  tile_first_col  <= cfg.data[11:0];
        dgtg_pkg::REG_TILE_VALID_COLS: tile_valid_cols <= cfg.data[5:0];
        dgtg_pkg::REG_COMPONENT:       component       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // captured item
  dgtg_pkg::item_t cur;
  always_ff @(posedge clk) begin
    if (cmd.load_item) cur <= item;
  end

  // memories
  logic [31:0] tile_mem [TILE_WORDS];
  logic [63:0] grad_mem [GE];
  logic [31:0] field_q;
  logic [63:0] grad_q;
  logic        tile_we;
  logic [TA_W-1:0] tile_wa, tile_ra;
  logic        grad_we;
  logic [GA_W-1:0] grad_wa, grad_ra;
  logic [63:0] grad_wd;

  always_ff @(posedge clk) begin
    if (tile_we) tile_mem[tile_wa] <= item.field_value;
    field_q <= tile_mem[tile_ra];
  end

  always_ff @(posedge clk) begin
    if (grad_we) grad_mem[grad_wa] <= grad_wd;
    grad_q <= grad_mem[grad_ra];
  end

  assign tile_we = cmd.load_item && (item.kind == dgtg_pkg::KIND_LOAD) &&
                   ({19'd0, item.field_slot} < 32'(TILE_WORDS));
  assign tile_wa = TA_W'(item.field_slot);

  // clearing sweep of the gradient store after reset
  logic [GA_W:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
  end

  // spans clamped
  logic [3:0] cs, rs;
  always_comb begin
    cs = (cur.col_span > 4'(MAX_SPAN)) ? 4'(MAX_SPAN) : cur.col_span;
    rs = (cur.row_span > 4'(MAX_SPAN)) ? 4'(MAX_SPAN) : cur.row_span;
  end

  // column / row walk
  logic [3:0]  k, h;
  logic [12:0] col;
  logic [12:0] tile_end;
  logic [8:0]  row;
  logic [15:0] px, py;
  logic        col_ok, row_ok_q;
  logic [31:0] w_q;
  logic [63:0] term, acc;
  logic        term_ok;

  assign col = 13'(cur.first_col) + 13'(k);
  assign tile_end = 13'(tile_first_col) +
    ((tile_valid_cols > 6'(TILE_COLS)) ? 13'(TILE_COLS) : 13'(tile_valid_cols));
  assign col_ok = (col >= 13'(tile_first_col)) && (col < tile_end) &&
                  (32'(col) < 32'(GRID_COLS));
  assign row = 9'(cur.first_row) + 9'(h);
  assign px  = 16'((k[2] ? cur.px_high : cur.px_low) >> {k[1:0], 4'd0});
  assign py  = 16'((h[2] ? cur.py_high : cur.py_low) >> {h[1:0], 4'd0});

  logic [31:0] slot_full;
  assign slot_full = 32'(col - 13'(tile_first_col)) * 32'(GRID_ROWS) + 32'(row);
  assign tile_ra = TA_W'(slot_full);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      k   <= '0;
      h   <= '0;
      acc <= '0;
    end
    if (cmd.col_start) h <= '0;
    if (cmd.row_fetch) begin
      row_ok_q <= (32'(row) < 32'(GRID_ROWS)) && (slot_full < 32'(TILE_WORDS));
      w_q      <= 32'(px) * 32'(py) >> weight_shift;
      h        <= h + 1'b1;
    end
    // signed field word times unsigned weight
    if (cmd.mul_step) begin
      term    <= 64'($signed({field_q[31], field_q}) * $signed({1'b0, w_q}));
      term_ok <= row_ok_q;
    end
    if (cmd.add_step && term_ok) acc <= acc + term;
    if (cmd.col_next) k <= k + 1'b1;
  end

  logic cell_ok;
  assign cell_ok = 32'(cur.cell_index) < 32'(CELLS);
  logic [GA_W-1:0] gidx;
  assign gidx = GA_W'({20'd0, cur.cell_index, 1'b0});

  // gradient store addressing
  always_comb begin
    grad_ra = gidx | GA_W'(component);
    if (cmd.read_x) grad_ra = gidx;
    if (cmd.read_y) grad_ra = gidx | GA_W'(1);
    grad_we = 1'b0;
    grad_wa = grad_ra;
    grad_wd = grad_q + acc;
    if (cmd.clear_step) begin
      grad_we = 1'b1;
      grad_wa = clr_cnt[GA_W-1:0];
      grad_wd = '0;
    end else if (cmd.grad_write) begin
      grad_we = 1'b1;
      grad_wa = gidx | GA_W'(component);
    end
  end

  // result register
  logic rd_y_q;
  always_ff @(posedge clk) begin
    rd_y_q <= cmd.read_y;
    if (cmd.read_y) begin
      result.read_index <= cur.cell_index;
      result.grad_x     <= cell_ok ? grad_q : 64'd0;
    end
    if (rd_y_q) result.grad_y <= cell_ok ? grad_q : 64'd0;
  end

  assign status.clear_done = (clr_cnt == (GA_W+1)'(GE - 1));
  assign status.col_done   = (k >= cs);
  assign status.col_ok     = col_ok && (rs != 4'd0) && cell_ok;
  assign status.row_last   = (h >= rs);
  assign status.cell_ok    = cell_ok;

`ifndef SYNTHESIS
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.row_fetch |-> (k < 4'(dgtg_pkg::SPAN_MAX_HW)))
    else $error("column index past span");
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> (grad_we && grad_wd == 64'd0))
    else $error("clear sweep wrote data");
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.grad_write |-> cell_ok)
    else $error("gradient write for bad cell");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/density_gradient_tile_gather_unit.sv
`default_nettype none
// load: tile word written at the accepting edge; read: ST_RD_X, ST_RD_Y and
//   ST_RD_WAIT register the result, offered in ST_OUT; gather: per column ST_COL,
//   per row inside the tile ST_ROW, ST_MUL, ST_ADD, then ST_COLEND; ST_GRD_RD/WR last
// throughput: one item at a time; the next is accepted once the controller is idle
// reset: synchronous; gradient store cleared by a sweep over all 2*CELLS entries
//   after reset, input not accepted meanwhile; field tile undefined until written
module density_gradient_tile_gather_unit #(
  parameter int TILE_COLS = 32,
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 4096,
  parameter int CELLS     = 4096,
  parameter int MAX_SPAN  = 8
) (
  input wire logic      clk,
  input wire logic      rst,
  dgtg_item_if.sink     in_ch,
  dgtg_result_if.source out_ch,
  dgtg_cfg_if.sink      cfg_ch
);

  dgtg_pkg::cmd_t    cmd;
  dgtg_pkg::status_t status;

  assign cfg_ch.ready = 1'b1;

  dgtg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.payload.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  dgtg_datapath #(
    .TILE_COLS (TILE_COLS),
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .CELLS     (CELLS),
    .MAX_SPAN  (MAX_SPAN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (in_ch.payload),
    .cfg_fire (cfg_ch.valid),
    .cfg      (cfg_ch.payload),
    .cmd      (cmd),
    .status   (status),
    .result   (out_ch.payload)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TILE_COLS   = 32;
  localparam int GRID_ROWS   = 256;
  localparam int GRID_COLS   = 4096;
  localparam int CELLS       = 4096;
  localparam int TILE_WORDS  = TILE_COLS * GRID_ROWS;
  localparam int SETTLE      = 300;
  localparam int PHASE_ITEMS = 36;
  localparam longint LIMIT   = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dgtg_item_if   item_ch ();
  dgtg_result_if grad_ch ();
  dgtg_cfg_if    cfg_ch ();

  density_gradient_tile_gather_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (item_ch),
    .out_ch (grad_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  always #5 clk = ~clk;

  // shadow copy of block state
  logic [31:0] shadow_tile [0:TILE_WORDS-1];
  logic [63:0] shadow_grad [0:2*CELLS-1];
  logic [4:0]  cur_shift;
  logic [11:0] cur_first_col;
  logic [5:0]  cur_valid_cols;
  logic        cur_component;

  dgtg_pkg::item_t   pending_items [$];
  dgtg_pkg::result_t expected_grads [$];
  int      errors = 0;
  int      send_idle_pct = 12;
  int      recv_idle_pct = 64;
  bit      hold_recv = 1'b0;
  longint  cycles = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] weight_at(input logic [63:0] lo, input logic [63:0] hi,
                                            input int k);
    logic [63:0] w;
    w = (k < 4) ? lo : hi;
    return w[16*(k%4) +: 16];
  endfunction

  // weighted tile sum for one cell
  function automatic logic [63:0] gather_sum(input dgtg_pkg::item_t it);
    int cs;
    int rs;
    int col;
    int row;
    int tile_end;
    int slot;
    logic [31:0] w;
    longint fval;
    logic [63:0] acc;
    cs = (it.col_span > 8) ? 8 : it.col_span;
    rs = (it.row_span > 8) ? 8 : it.row_span;
    tile_end = cur_first_col + ((cur_valid_cols > TILE_COLS) ? TILE_COLS : cur_valid_cols);
    acc = '0;
    for (int k = 0; k < cs; k++) begin
      col = it.first_col + k;
      if (col < cur_first_col || col >= tile_end || col >= GRID_COLS) continue;
      for (int h = 0; h < rs; h++) begin
        row = it.first_row + h;
        if (row >= GRID_ROWS) continue;
        slot = (col - cur_first_col) * GRID_ROWS + row;
        w = ({16'b0, weight_at(it.px_low, it.px_high, k)} *
             {16'b0, weight_at(it.py_low, it.py_high, h)}) >> cur_shift;
        fval = longint'(signed'(shadow_tile[slot]));
        acc += fval * longint'({32'b0, w});
      end
    end
    return acc;
  endfunction

  // update shadow state for one accepted item
  function automatic void track_item(input dgtg_pkg::item_t it);
    dgtg_pkg::result_t r;
    case (it.kind)
      dgtg_pkg::KIND_LOAD: shadow_tile[it.field_slot] = it.field_value;
      dgtg_pkg::KIND_GATHER: begin
        shadow_grad[{it.cell_index, cur_component}] += gather_sum(it);
      end
      dgtg_pkg::KIND_READ: begin
        r.read_index = it.cell_index;
        r.grad_x = shadow_grad[{it.cell_index, 1'b0}];
        r.grad_y = shadow_grad[{it.cell_index, 1'b1}];
        expected_grads.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.payload <= '0;
    end else begin
      if (item_ch.valid && item_ch.ready) track_item(item_ch.payload);
      if (item_ch.valid && !item_ch.ready) begin
        item_ch.valid <= 1'b1;
      end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item_ch.valid <= 1'b1;
        item_ch.payload <= pending_items.pop_front();
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    dgtg_pkg::result_t want;
    if (rst) begin
      grad_ch.ready <= 1'b0;
    end else begin
      if (grad_ch.valid && grad_ch.ready) begin
        if (expected_grads.size() == 0) begin
          report("unexpected result", 64'(grad_ch.payload.read_index), '0);
        end else begin
          want = expected_grads.pop_front();
          if (grad_ch.payload.read_index !== want.read_index)
            report("read_index", 64'(grad_ch.payload.read_index), 64'(want.read_index));
          if (grad_ch.payload.grad_x !== want.grad_x)
            report("grad_x", grad_ch.payload.grad_x, want.grad_x);
          if (grad_ch.payload.grad_y !== want.grad_y)
            report("grad_y", grad_ch.payload.grad_y, want.grad_y);
        end
      end
      grad_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload.index <= idx;
    cfg_ch.payload.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      dgtg_pkg::REG_WEIGHT_SHIFT:    cur_shift = data[4:0];
      dgtg_pkg::REG_TILE_FIRST_COL:  cur_first_col = data[11:0];
      dgtg_pkg::REG_TILE_VALID_COLS: cur_valid_cols = data[5:0];
      dgtg_pkg::REG_COMPONENT:       cur_component = data[0];
      default: ;
    endcase
  endtask

  task automatic set_tile(input int shift, input int first_col, input int ncols, input int comp);
    cfg_write(dgtg_pkg::REG_WEIGHT_SHIFT, shift);
    cfg_write(dgtg_pkg::REG_TILE_FIRST_COL, first_col);
    cfg_write(dgtg_pkg::REG_TILE_VALID_COLS, ncols);
    cfg_write(dgtg_pkg::REG_COMPONENT, comp);
  endtask

  // block is idle: every transfer done, then gathers given time to finish
  task automatic drain();
    wait (pending_items.size() == 0 && !item_ch.valid && expected_grads.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic dgtg_pkg::item_t noise_item();
    dgtg_pkg::item_t it;
    it.kind        = 2'($urandom);
    it.field_slot  = 13'($urandom);
    it.field_value = $urandom;
    it.first_col   = 12'($urandom);
    it.first_row   = 8'($urandom);
    it.col_span    = 4'($urandom);
    it.row_span    = 4'($urandom);
    it.px_low      = {$urandom, $urandom};
    it.px_high     = {$urandom, $urandom};
    it.py_low      = {$urandom, $urandom};
    it.py_high     = {$urandom, $urandom};
    it.cell_index  = 12'($urandom);
    return it;
  endfunction

  // cells reach only the loaded tile columns and rows; mostly a small set of cell indexes
  function automatic dgtg_pkg::item_t random_item();
    dgtg_pkg::item_t it;
    int pick;
    int rel;
    it = noise_item();
    pick = $urandom_range(99);
    if (pick < 15) it.kind = dgtg_pkg::KIND_LOAD;
    else if (pick < 60) it.kind = dgtg_pkg::KIND_GATHER;
    else if (pick < 95) it.kind = dgtg_pkg::KIND_READ;
    else it.kind = dgtg_pkg::KIND_UNKNOWN;
    if ($urandom_range(3) != 0) it.cell_index = 12'($urandom_range(15));
    if ($urandom_range(1) == 0) rel = int'($urandom_range(8)) - 8;
    else rel = 24 + int'($urandom_range(8));
    it.first_col = 12'(int'(cur_first_col) + rel);
    if ($urandom_range(1) == 0) it.first_row = 8'($urandom_range(8));
    else it.first_row = 8'(248 + $urandom_range(7));
    if ($urandom_range(3) != 0) begin
      it.col_span = 4'($urandom_range(8));
      it.row_span = 4'($urandom_range(8));
    end
    return it;
  endfunction

  function automatic dgtg_pkg::item_t read_of(input int cell_idx);
    dgtg_pkg::item_t it;
    it = noise_item();
    it.kind = dgtg_pkg::KIND_READ;
    it.cell_index = 12'(cell_idx);
    return it;
  endfunction

  function automatic dgtg_pkg::item_t gather_of(input int fc, input int fr, input int cs,
                                                input int rs, input int cell_idx,
                                                input logic [63:0] px, input logic [63:0] py);
    dgtg_pkg::item_t it;
    it = noise_item();
    it.kind = dgtg_pkg::KIND_GATHER;
    it.first_col = 12'(fc);
    it.first_row = 8'(fr);
    it.col_span = 4'(cs);
    it.row_span = 4'(rs);
    it.px_low = px;
    it.px_high = px;
    it.py_low = py;
    it.py_high = py;
    it.cell_index = 12'(cell_idx);
    return it;
  endfunction

  initial begin
    dgtg_pkg::item_t it;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    cur_shift = '0;
    cur_first_col = '0;
    cur_valid_cols = 6'd32;
    cur_component = 1'b0;
    foreach (shadow_tile[i]) shadow_tile[i] = '0;
    foreach (shadow_grad[i]) shadow_grad[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // load tile columns 0-7 and 24-31, rows 0-15 and 248-255: every word a gather reaches
    set_tile(0, 0, 32, 0);
    for (int c = 0; c < TILE_COLS; c++) begin
      if (c >= 8 && c < 24) continue;
      for (int r = 0; r < GRID_ROWS; r++) begin
        if (r >= 16 && r < 248) continue;
        it = noise_item();
        it.kind = dgtg_pkg::KIND_LOAD;
        it.field_slot = 13'(c * GRID_ROWS + r);
        if (c == 0 && r == 0) it.field_value = 32'h8000_0000;
        else if (c == 0 && r == 1) it.field_value = 32'h7fff_ffff;
        pending_items.push_back(it);
      end
    end
    drain();

    // directed cases: extreme weights and fields, spans, edges, unknown kind
    pending_items.push_back(gather_of(0, 0, 2, 2, 0, '1, '1));
    pending_items.push_back(read_of(0));
    pending_items.push_back(gather_of(0, 0, 8, 8, 1, '1, '1));
    pending_items.push_back(gather_of(3, 5, 0, 8, 2, '1, '1));
    pending_items.push_back(gather_of(0, 5, 15, 15, 2, {4{16'h1234}}, {4{16'hffff}}));
    pending_items.push_back(gather_of(28, 252, 8, 8, 3, '1, {4{16'h0001}}));
    pending_items.push_back(gather_of(4095, 0, 8, 8, 4, '1, '1));
    it = noise_item();
    it.kind = dgtg_pkg::KIND_UNKNOWN;
    pending_items.push_back(it);
    pending_items.push_back(read_of(1));
    pending_items.push_back(read_of(2));
    pending_items.push_back(read_of(3));
    pending_items.push_back(read_of(4));
    pending_items.push_back(read_of(4095));
    drain();
    set_tile(31, 4090, 32, 1);
    pending_items.push_back(gather_of(4088, 0, 8, 8, 4095, '1, '1));
    pending_items.push_back(gather_of(4090, 8, 8, 8, 0, '1, '1));
    pending_items.push_back(read_of(4095));
    pending_items.push_back(read_of(0));
    drain();

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      if (p >= 2) begin
        send_idle_pct = (p < 4) ? 64 : 0;
        recv_idle_pct = (p < 4) ? 12 : 0;
      end
      case (p)
        0: set_tile(0, 0, 32, 0);
        1: set_tile(31, 4080, 63, 1);
        2: set_tile(8, 100, 0, 0);
        3: set_tile($urandom_range(31), $urandom_range(4095), 40, 1);
        4: set_tile(4, 2000, 17, 0);
        default: set_tile(16, 7, 32, 1);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) pending_items.push_back(random_item());
      // long receiver hold while items keep coming
      if (p == 4) begin
        fork
          begin
            hold_recv = 1'b1;
            repeat (3000) @(posedge clk);
            hold_recv = 1'b0;
          end
        join_none
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
